@@ src/dac_pkg.sv @@
`timescale 1ns / 1ps

package dac_pkg;

    // Table geometry and count width
    localparam int PROCS      = 8;
    localparam int RES_TYPES  = 4;
    localparam int COUNT_BITS = 8;

    localparam int ROW_BITS     = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int COL_BITS     = (RES_TYPES > 1) ? $clog2(RES_TYPES) : 1;
    localparam int ROW_CNT_BITS = $clog2(PROCS + 1);
    localparam int COL_CNT_BITS = $clog2(RES_TYPES + 1);
    // Work vector holds free count plus every process's allocation without wrapping
    localparam int WORK_BITS    = COUNT_BITS + $clog2(PROCS + 1);

    // Fixed field widths of the ports
    localparam int KIND_BITS      = 3;
    localparam int PROCESS_BITS   = 3;
    localparam int RESOURCE_BITS  = 2;
    localparam int FIELD_BITS     = 8;
    localparam int REQ_PORTS      = 4;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 4;
    localparam int NPROC_BITS     = 4;
    localparam int NRES_BITS      = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_PROCS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_RES   = 1'b1;

    localparam logic [NPROC_BITS-1:0] NPROC_RESET = 4'd8;
    localparam logic [NRES_BITS-1:0]  NRES_RESET  = 3'd4;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOAD_MAX  = 3'd0,
        KIND_LOAD_HELD = 3'd1,
        KIND_LOAD_FREE = 3'd2,
        KIND_QUERY     = 3'd3,
        KIND_REQUEST   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_EXCEED = 2'd1,
        ST_UNSAFE = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic signed [COUNT_BITS:0] need_t;
    typedef logic [WORK_BITS-1:0]    work_t;
    typedef logic [ROW_BITS-1:0]     row_idx_t;
    typedef logic [COL_BITS-1:0]     col_idx_t;
    typedef logic [ROW_CNT_BITS-1:0] row_cnt_t;
    typedef logic [COL_CNT_BITS-1:0] col_cnt_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic apply;
        logic revert;
        logic scan_init;
        logic scan_step;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  proc_bad;
        logic  res_bad;
        logic  req_fits;
        logic  scan_end;
        logic  scan_safe;
    } dp_status_t;

endpackage

@@ src/dac_datapath.sv @@
`timescale 1ns / 1ps

module dac_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [dac_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dac_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [dac_pkg::KIND_BITS-1:0]        kind,
    input  logic [dac_pkg::PROCESS_BITS-1:0]     process,
    input  logic [dac_pkg::RESOURCE_BITS-1:0]    resource,
    input  logic [dac_pkg::FIELD_BITS-1:0]       value,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r0,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r1,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r2,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r3,
    input  dac_pkg::dp_cmd_t                     cmd,
    output dac_pkg::dp_status_t                  st
);
    import dac_pkg::*;

    // Configuration
    logic [NPROC_BITS-1:0] nproc_reg, nproc_next;
    logic [NRES_BITS-1:0]  nres_reg, nres_next;
    row_cnt_t rows_used;
    col_cnt_t cols_used;

    // Latched item
    logic [KIND_BITS-1:0]     kind_reg;
    logic [PROCESS_BITS-1:0]  proc_reg;
    logic [RESOURCE_BITS-1:0] res_reg;
    count_t                   val_reg;
    count_t                   req_reg [RES_TYPES];

    // Tables
    count_t max_reg  [PROCS][RES_TYPES];
    count_t held_reg [PROCS][RES_TYPES];
    need_t  need_reg [PROCS][RES_TYPES];
    count_t free_reg [RES_TYPES];
    count_t max_next  [PROCS][RES_TYPES];
    count_t held_next [PROCS][RES_TYPES];
    need_t  need_next [PROCS][RES_TYPES];
    count_t free_next [RES_TYPES];

    // Safety scan
    row_idx_t   scan_row_reg, scan_row_next;
    logic [PROCS-1:0] done_reg, done_next;
    row_cnt_t   finished_reg, finished_next;
    logic       progress_reg, progress_next;
    work_t      work_reg [RES_TYPES];
    work_t      work_next [RES_TYPES];

    row_idx_t   proc_row;
    col_idx_t   res_col;
    logic [RES_TYPES-1:0] col_active;
    logic       row_fit;
    logic       fits;
    logic       last_row;
    row_cnt_t   fin_after;
    logic       req_ok;
    count_t     req_in [RES_TYPES];
    count_t     new_held;

    // Clamp the register values into the legal range
    always_comb
    begin
        if (nproc_reg == '0)
            rows_used = row_cnt_t'(1);
        else if (int'(nproc_reg) > PROCS)
            rows_used = row_cnt_t'(PROCS);
        else
            rows_used = row_cnt_t'(nproc_reg);

        if (nres_reg == '0)
            cols_used = col_cnt_t'(1);
        else if (int'(nres_reg) > RES_TYPES)
            cols_used = col_cnt_t'(RES_TYPES);
        else
            cols_used = col_cnt_t'(nres_reg);
    end

    always_comb
    begin
        nproc_next = nproc_reg;
        nres_next  = nres_reg;
        if (cfg_write)
        begin
            if (cfg_index == CFG_NUM_PROCS)
                nproc_next = cfg_data[NPROC_BITS-1:0];
            else if (cfg_index == CFG_NUM_RES)
                nres_next = cfg_data[NRES_BITS-1:0];
        end
    end

    // Request columns past the four ports ask for nothing
    always_comb
    begin
        for (int r = 0; r < RES_TYPES; r++)
        begin
            unique case (r)
                0:       req_in[r] = count_t'(req_r0);
                1:       req_in[r] = count_t'(req_r1);
                2:       req_in[r] = count_t'(req_r2);
                3:       req_in[r] = count_t'(req_r3);
                default: req_in[r] = '0;
            endcase
        end
    end

    assign proc_row = row_idx_t'(proc_reg);
    assign res_col  = col_idx_t'(res_reg);

    always_comb
    begin
        for (int r = 0; r < RES_TYPES; r++)
            col_active[r] = (r < int'(cols_used));
    end

    // Row compare on the scan row, request check on the item's row;
    // a negative need fits any work vector
    always_comb
    begin
        row_fit = 1'b1;
        req_ok  = 1'b1;
        for (int r = 0; r < RES_TYPES; r++)
        begin
            if (col_active[r])
            begin
                if (!need_reg[scan_row_reg][r][COUNT_BITS] &&
                    (work_t'(count_t'(need_reg[scan_row_reg][r])) > work_reg[r]))
                    row_fit = 1'b0;
                if ((req_reg[r] > free_reg[r]) ||
                    (need_t'(req_reg[r]) > need_reg[proc_row][r]))
                    req_ok = 1'b0;
            end
        end
    end

    assign fits      = !done_reg[scan_row_reg] && row_fit;
    assign last_row  = (8'(scan_row_reg) == 8'(rows_used - row_cnt_t'(1)));
    assign fin_after = finished_reg + row_cnt_t'(fits);

    always_comb
    begin
        st.kind      = kind_t'(kind_reg);
        st.proc_bad  = (8'(proc_reg) >= 8'(rows_used));
        st.res_bad   = (8'(res_reg) >= 8'(cols_used));
        st.req_fits  = req_ok;
        st.scan_safe = (fin_after == rows_used);
        st.scan_end  = (fin_after == rows_used) ||
                       (last_row && !(progress_reg || fits));
    end

    // Table updates
    always_comb
    begin
        max_next  = max_reg;
        held_next = held_reg;
        need_next = need_reg;
        free_next = free_reg;
        new_held  = '0;

        if (cmd.load)
        begin
            unique case (kind_t'(kind_reg))
                KIND_LOAD_MAX:
                begin
                    max_next[proc_row][res_col]  = val_reg;
                    need_next[proc_row][res_col] = need_t'(val_reg) -
                                                   need_t'(held_reg[proc_row][res_col]);
                end
                KIND_LOAD_HELD:
                begin
                    held_next[proc_row][res_col] = val_reg;
                    need_next[proc_row][res_col] = need_t'(max_reg[proc_row][res_col]) -
                                                   need_t'(val_reg);
                end
                KIND_LOAD_FREE:
                    free_next[res_col] = val_reg;
                default:
                    free_next = free_reg;
            endcase
        end

        if (cmd.apply || cmd.revert)
        begin
            for (int r = 0; r < RES_TYPES; r++)
            begin
                if (col_active[r])
                begin
                    if (cmd.apply)
                    begin
                        new_held     = held_reg[proc_row][r] + req_reg[r];
                        free_next[r] = free_reg[r] - req_reg[r];
                    end
                    else
                    begin
                        new_held     = held_reg[proc_row][r] - req_reg[r];
                        free_next[r] = free_reg[r] + req_reg[r];
                    end
                    held_next[proc_row][r] = new_held;
                    need_next[proc_row][r] = need_t'(max_reg[proc_row][r]) -
                                             need_t'(new_held);
                end
            end
        end
    end

    // Safety scan: one row per cycle, passes repeat until no row is granted or every row in use has finished
    always_comb
    begin
        scan_row_next = scan_row_reg;
        done_next     = done_reg;
        finished_next = finished_reg;
        progress_next = progress_reg;
        work_next     = work_reg;

        if (cmd.scan_init)
        begin
            scan_row_next = '0;
            done_next     = '0;
            finished_next = '0;
            progress_next = 1'b0;
            for (int r = 0; r < RES_TYPES; r++)
                work_next[r] = work_t'(free_reg[r]);
        end
        else if (cmd.scan_step)
        begin
            if (fits)
            begin
                for (int r = 0; r < RES_TYPES; r++)
                    work_next[r] = work_reg[r] + work_t'(held_reg[scan_row_reg][r]);
                done_next[scan_row_reg] = 1'b1;
                finished_next = fin_after;
            end
            if (last_row)
            begin
                scan_row_next = '0;
                progress_next = 1'b0;
            end
            else
            begin
                scan_row_next = scan_row_reg + row_idx_t'(1);
                progress_next = progress_reg || fits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nproc_reg <= NPROC_RESET;
            nres_reg  <= NRES_RESET;
            for (int p = 0; p < PROCS; p++)
            begin
                for (int r = 0; r < RES_TYPES; r++)
                begin
                    max_reg[p][r]  <= '0;
                    held_reg[p][r] <= '0;
                    need_reg[p][r] <= '0;
                end
            end
            for (int r = 0; r < RES_TYPES; r++)
                free_reg[r] <= '0;
            scan_row_reg <= '0;
            done_reg     <= '0;
            finished_reg <= '0;
            progress_reg <= 1'b0;
        end
        else
        begin
            nproc_reg    <= nproc_next;
            nres_reg     <= nres_next;
            max_reg      <= max_next;
            held_reg     <= held_next;
            need_reg     <= need_next;
            free_reg     <= free_next;
            scan_row_reg <= scan_row_next;
            done_reg     <= done_next;
            finished_reg <= finished_next;
            progress_reg <= progress_next;
        end
    end

    // Payload registers: item fields and work vector
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            proc_reg <= process;
            res_reg  <= resource;
            val_reg  <= count_t'(value);
            req_reg  <= req_in;
        end
        work_reg <= work_next;
    end

endmodule

@@ src/dac_controller.sv @@
`timescale 1ns / 1ps

module dac_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dac_pkg::STATUS_BITS-1:0]  status,
    output logic                             safe,
    input  dac_pkg::dp_status_t              st,
    output dac_pkg::dp_cmd_t                 cmd
);
    import dac_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_START  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_REVERT = 6'b010000,
        S_RESP   = 6'b100000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    status_t    pend_status_reg, pend_status_next;
    logic       pend_safe_reg, pend_safe_next;
    logic       out_valid_reg, out_valid_next;
    status_t    out_status_reg, out_status_next;
    logic       out_safe_reg, out_safe_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign safe      = out_safe_reg;

    always_comb
    begin
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_safe_next   = pend_safe_reg;
        out_status_next  = out_status_reg;
        out_safe_next    = out_safe_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cmd              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture      = 1'b1;
                    pend_status_next = ST_OK;
                    pend_safe_next   = 1'b0;
                    state_next       = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                unique case (st.kind)
                    KIND_LOAD_MAX, KIND_LOAD_HELD:
                    begin
                        if (st.proc_bad || st.res_bad)
                            pend_status_next = ST_RANGE;
                        else
                            cmd.load = 1'b1;
                    end
                    KIND_LOAD_FREE:
                    begin
                        if (st.res_bad)
                            pend_status_next = ST_RANGE;
                        else
                            cmd.load = 1'b1;
                    end
                    KIND_QUERY:
                        state_next = S_START;
                    KIND_REQUEST:
                    begin
                        if (st.proc_bad)
                            pend_status_next = ST_RANGE;
                        else if (!st.req_fits)
                            pend_status_next = ST_EXCEED;
                        else
                        begin
                            cmd.apply  = 1'b1;
                            state_next = S_START;
                        end
                    end
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_START:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_end)
                begin
                    if (st.scan_safe)
                    begin
                        pend_safe_next = 1'b1;
                        state_next     = S_RESP;
                    end
                    else if (st.kind == KIND_REQUEST)
                        state_next = S_REVERT;
                    else
                        state_next = S_RESP;
                end
            end
            S_REVERT:
            begin
                cmd.revert       = 1'b1;
                pend_status_next = ST_UNSAFE;
                state_next       = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_safe_next   = pend_safe_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_safe_reg   <= pend_safe_next;
        out_status_reg  <= out_status_next;
        out_safe_reg    <= out_safe_next;
    end

endmodule

@@ src/deadlock_avoidance_checker.sv @@
`timescale 1ns / 1ps

// Banker's-algorithm resource guard. Load items write one maximum-claim entry, one
// allocation entry or one free count; the need table follows as claim minus
// allocation. A safety query scans the process rows one per cycle, granting any
// unfinished row whose need fits the work vector, and repeats passes until a pass
// grants nothing or every row in use has finished. A request is checked against
// need and free count, applied, scanned, and backed out if the state is unsafe.
// Each item returns exactly one result item (status, safe). One item is worked on
// at a time: a load or a rejected item passes through decode to the result state;
// a query or an applied request also runs the scan-start state and the scan, and a
// request that is backed out adds the revert state. Input is ready again in the
// cycle the result turns valid. The next item is taken while a finished result
// still waits in the output register.
// Configuration writes (num_processes at index 0, num_resources at index 1) take
// effect at once and belong only to idle periods; num_resources keeps the low three
// data bits, and values outside their range are clamped to 1..8 rows and 1..4 columns.
module deadlock_avoidance_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [dac_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dac_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dac_pkg::KIND_BITS-1:0]        kind,
    input  logic [dac_pkg::PROCESS_BITS-1:0]     process,
    input  logic [dac_pkg::RESOURCE_BITS-1:0]    resource,
    input  logic [dac_pkg::FIELD_BITS-1:0]       value,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r0,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r1,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r2,
    input  logic [dac_pkg::FIELD_BITS-1:0]       req_r3,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dac_pkg::STATUS_BITS-1:0]      status,
    output logic                                 safe
);
    import dac_pkg::*;

    // Command and status between the sequencer and the tables
    dp_cmd_t    cmd;
    dp_status_t st;

    // Sequencer: item handshake, decode, scan control, result register
    dac_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .safe      (safe),
        .st        (st),
        .cmd       (cmd)
    );

    // Tables, configuration, work vector and the row compare
    dac_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .process   (process),
        .resource  (resource),
        .value     (value),
        .req_r0    (req_r0),
        .req_r1    (req_r1),
        .req_r2    (req_r2),
        .req_r3    (req_r3),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

@@ src/dac_checker.sv @@
`timescale 1ns / 1ps

module dac_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [dac_pkg::STATUS_BITS-1:0]  status,
    input  logic                             safe
);
    import dac_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(safe))
        else $error("stalled result changed or dropped");

    // One item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    // Safe is only reported with a done or granted status
    a_safe_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && safe |-> status == ST_OK)
        else $error("safe flag with a failing status");

    // A new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in progress");

endmodule

bind deadlock_avoidance_checker dac_checker u_dac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .safe      (safe)
);

@@ test/tb_deadlock_avoidance_checker.sv @@
`timescale 1ns / 1ps

module tb_deadlock_avoidance_checker;
    import dac_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int IDLE_PCT      = 14;
    localparam int LONG_HOLD     = 400;
    // Every item returns a result, so the block is idle once the last result is in;
    // keep a short margin anyway.
    localparam int SETTLE_CYCLES = 8;

    // Kind codes the block ignores
    localparam logic [KIND_BITS-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [KIND_BITS-1:0]                 kind;
        logic [PROCESS_BITS-1:0]              proc_id;
        logic [RESOURCE_BITS-1:0]             res_id;
        logic [FIELD_BITS-1:0]                value;
        logic [REQ_PORTS-1:0][FIELD_BITS-1:0] amount;
    } op_t;

    typedef struct packed {
        status_t status;
        logic    safe;
    } verdict_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      out_valid;
    logic                      out_ready;
    logic [STATUS_BITS-1:0]    status;
    logic                      safe;
    op_t                       cur_op;

    // Traffic bookkeeping
    op_t      op_queue [$];
    verdict_t verdicts_due [$];
    int       ops_queued   = 0;
    int       offered_cnt  = 0;
    int       accepted_cnt = 0;
    int       errors       = 0;
    int       cycles       = 0;
    logic     steady       = 1'b0;
    int       holds_asked  = 0;
    int       holds_taken  = 0;
    int       hold_left    = 0;

    // Shadow of the guard: raw register values and the four tables
    logic [NPROC_BITS-1:0] rows_raw;
    logic [NRES_BITS-1:0]  cols_raw;
    count_t                claim_tbl [PROCS][RES_TYPES];
    count_t                alloc_tbl [PROCS][RES_TYPES];
    need_t                 need_tbl  [PROCS][RES_TYPES];
    count_t                avail_vec [RES_TYPES];

    deadlock_avoidance_checker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (cur_op.kind),
        .process   (cur_op.proc_id),
        .resource  (cur_op.res_id),
        .value     (cur_op.value),
        .req_r0    (cur_op.amount[0]),
        .req_r1    (cur_op.amount[1]),
        .req_r2    (cur_op.amount[2]),
        .req_r3    (cur_op.amount[3]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .safe      (safe)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Clamp the register values the way the block does
    function automatic int rows_in_use();
        if (rows_raw == 0)
            return 1;
        if (rows_raw > PROCS)
            return PROCS;
        return int'(rows_raw);
    endfunction

    function automatic int cols_in_use();
        if (cols_raw == 0)
            return 1;
        if (cols_raw > RES_TYPES)
            return RES_TYPES;
        return int'(cols_raw);
    endfunction

    function automatic void refresh_need(int p, int r);
        need_tbl[p][r] = $signed({1'b0, claim_tbl[p][r]}) - $signed({1'b0, alloc_tbl[p][r]});
    endfunction

    // Banker's safety scan: keep granting unfinished rows whose need fits the work
    // vector until a full pass grants nothing or every row in use is done.
    function automatic logic system_is_safe();
        int               np;
        int               nr;
        int               finished;
        work_t            work [RES_TYPES];
        logic [PROCS-1:0] done;
        logic             progress;
        logic             fits;
        np = rows_in_use();
        nr = cols_in_use();
        for (int r = 0; r < nr; r++)
            work[r] = work_t'(avail_vec[r]);
        done     = '0;
        finished = 0;
        progress = 1'b1;
        while (finished < np && progress) begin
            progress = 1'b0;
            for (int p = 0; p < np; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    // A negative need fits any work vector
                    for (int r = 0; r < nr; r++)
                        if (need_tbl[p][r] > $signed({1'b0, work[r]}))
                            fits = 1'b0;
                    if (fits) begin
                        for (int r = 0; r < nr; r++)
                            work[r] = work[r] + work_t'(alloc_tbl[p][r]);
                        done[p]  = 1'b1;
                        finished = finished + 1;
                        progress = 1'b1;
                    end
                end
            end
        end
        return finished == np;
    endfunction

    // Work out the verdict of one accepted item and advance the shadow tables
    function automatic verdict_t predict_verdict(op_t op);
        verdict_t v;
        int       np;
        int       nr;
        int       p;
        np       = rows_in_use();
        nr       = cols_in_use();
        p        = int'(op.proc_id);
        v.status = ST_OK;
        v.safe   = 1'b0;
        case (op.kind)
            KIND_LOAD_MAX, KIND_LOAD_HELD: begin
                if (op.proc_id >= np || op.res_id >= nr)
                    v.status = ST_RANGE;
                else begin
                    if (op.kind == KIND_LOAD_MAX)
                        claim_tbl[p][op.res_id] = op.value;
                    else
                        alloc_tbl[p][op.res_id] = op.value;
                    refresh_need(p, int'(op.res_id));
                end
            end
            KIND_LOAD_FREE: begin
                if (op.res_id >= nr)
                    v.status = ST_RANGE;
                else
                    avail_vec[op.res_id] = op.value;
            end
            KIND_QUERY: v.safe = system_is_safe();
            KIND_REQUEST: begin
                if (op.proc_id >= np)
                    v.status = ST_RANGE;
                else begin
                    // Any column over the free count or the need rejects the whole request
                    for (int r = 0; r < nr; r++)
                        if (op.amount[r] > avail_vec[r] ||
                            $signed({1'b0, op.amount[r]}) > need_tbl[p][r])
                            v.status = ST_EXCEED;
                    if (v.status == ST_OK) begin
                        for (int r = 0; r < nr; r++) begin
                            avail_vec[r]    = avail_vec[r] - op.amount[r];
                            alloc_tbl[p][r] = alloc_tbl[p][r] + op.amount[r];
                            refresh_need(p, r);
                        end
                        if (system_is_safe())
                            v.safe = 1'b1;
                        else begin
                            // Back the grant out again
                            for (int r = 0; r < nr; r++) begin
                                avail_vec[r]    = avail_vec[r] + op.amount[r];
                                alloc_tbl[p][r] = alloc_tbl[p][r] - op.amount[r];
                                refresh_need(p, r);
                            end
                            v.status = ST_UNSAFE;
                        end
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // Sender: offer the next item once the current one is taken, idle now and then
    always @(negedge clk) begin
        if (!in_valid || accepted_cnt == offered_cnt) begin
            if (op_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                cur_op      <= op_queue.pop_front();
                in_valid    <= 1'b1;
                offered_cnt <= offered_cnt + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the block backs up
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_taken != holds_asked) begin
            out_ready   <= 1'b0;
            hold_left   <= LONG_HOLD;
            holds_taken <= holds_taken + 1;
        end
        else
            out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: check the result first, then predict the item taken in the same cycle
    always @(posedge clk) begin
        verdict_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result: status %0d safe %0d", status, safe);
                    errors++;
                end
                else begin
                    want = verdicts_due.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (safe !== want.safe) begin
                        $error("safe: expected %0d, got %0d", want.safe, safe);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                verdicts_due.push_back(predict_verdict(cur_op));
                accepted_cnt++;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_op(logic [KIND_BITS-1:0] kind, logic [PROCESS_BITS-1:0] p,
                           logic [RESOURCE_BITS-1:0] r, logic [FIELD_BITS-1:0] v,
                           logic [REQ_PORTS*FIELD_BITS-1:0] amounts);
        op_t op;
        op.kind    = kind;
        op.proc_id = p;
        op.res_id  = r;
        op.value   = v;
        op.amount  = amounts;
        op_queue.push_back(op);
        // Ignored kinds do not count toward the phase size
        if (kind <= KIND_REQUEST)
            ops_queued++;
    endtask

    // Write one register; only called while the block is idle
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_NUM_PROCS)
            rows_raw = data;
        else
            cols_raw = data[NRES_BITS-1:0];
    endtask

    // Hold until every item is taken and every result is in, then settle
    task automatic drain();
        while (!(op_queue.size() == 0 && offered_cnt == accepted_cnt &&
                 verdicts_due.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One well-formed scenario: fill the free vector and both tables for every row
    // and column in use, then several rounds of a cell update followed by
    // requests and queries. Values stay small mostly so requests often fit.
    task automatic add_scenario();
        int                                   np;
        int                                   nr;
        int                                   top;
        logic [FIELD_BITS-1:0]                claim;
        logic [REQ_PORTS-1:0][FIELD_BITS-1:0] ask;
        np  = rows_in_use();
        nr  = cols_in_use();
        top = ($urandom_range(7) == 0) ? 255 : 12;
        for (int r = 0; r < nr; r++)
            push_op(KIND_LOAD_FREE, $urandom, r, $urandom_range(0, top), $urandom);
        for (int p = 0; p < np; p++)
            for (int r = 0; r < nr; r++) begin
                claim = $urandom_range(0, top);
                push_op(KIND_LOAD_MAX, p, r, claim, $urandom);
                // Now and then hold more than the claim, giving a negative need
                push_op(KIND_LOAD_HELD, p, r,
                        ($urandom_range(15) == 0) ? $urandom_range(0, top)
                                                  : $urandom_range(0, claim),
                        $urandom);
            end
        repeat ($urandom_range(2, 5)) begin
            push_op($urandom_range(KIND_LOAD_MAX, KIND_LOAD_FREE), $urandom_range(0, np - 1),
                    $urandom_range(0, nr - 1), $urandom_range(0, top), $urandom);
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(3) == 0)
                    push_op(KIND_QUERY, $urandom, $urandom, $urandom, $urandom);
                else begin
                    for (int r = 0; r < REQ_PORTS; r++)
                        ask[r] = ($urandom_range(9) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 2);
                    push_op(KIND_REQUEST,
                            ($urandom_range(9) == 0) ? $urandom_range(0, 7)
                                                     : $urandom_range(0, np - 1),
                            $urandom, $urandom, ask);
                end
            end
        end
    endtask

    // Configure, queue a mix of scenarios and fully random items, and drain
    task automatic run_phase(logic [CFG_DATA_BITS-1:0] rows, logic [CFG_DATA_BITS-1:0] cols,
                             int n, logic calm, logic hold_off);
        int target;
        write_reg(CFG_NUM_PROCS, rows);
        write_reg(CFG_NUM_RES, cols);
        steady = calm;
        if (hold_off)
            holds_asked++;
        target = ops_queued + n;
        while (ops_queued < target) begin
            if ($urandom_range(99) < 15)
                push_op($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                add_scenario();
        end
        drain();
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        cur_op    = '0;
        rows_raw  = NPROC_RESET;
        cols_raw  = NRES_RESET;
        for (int p = 0; p < PROCS; p++)
            for (int r = 0; r < RES_TYPES; r++) begin
                claim_tbl[p][r] = '0;
                alloc_tbl[p][r] = '0;
                need_tbl[p][r]  = '0;
            end
        for (int r = 0; r < RES_TYPES; r++)
            avail_vec[r] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset geometry of eight rows by four columns
        push_op(KIND_QUERY, 0, 0, 0, 0);                      // all-zero tables are safe
        push_op(KIND_LOAD_MAX, 0, 0, 8'hFF, 0);
        push_op(KIND_LOAD_FREE, 0, 0, 8'hFF, 0);
        push_op(KIND_REQUEST, 0, 0, 0, 32'h0000_00FF);        // take the whole column
        push_op(KIND_LOAD_HELD, 7, 3, 8'hFF, 0);              // negative need
        push_op(KIND_REQUEST, 7, 0, 0, 32'h0000_0000);        // zero against negative need
        push_op(KIND_QUERY, 0, 0, 0, 0);
        push_op(KIND_LOAD_MAX, 3, 2, 8'd200, 0);
        push_op(KIND_LOAD_FREE, 0, 2, 8'd10, 0);
        push_op(KIND_REQUEST, 3, 0, 0, 32'h0005_0000);        // fits, but leaves it unsafe
        push_op(KIND_REQUEST, 3, 0, 0, 32'h000B_0000);        // above the free count
        push_op(KIND_REQUEST, 1, 0, 0, 32'hFFFF_FFFF);        // above need and free
        push_op(KIND_LOAD_FREE, 0, 2, 8'd200, 0);
        push_op(KIND_REQUEST, 3, 0, 0, 32'h00C8_0000);
        push_op(KIND_SPARE_FIRST, 7, 3, 8'hFF, 32'hFFFF_FFFF);
        push_op(KIND_SPARE_LAST, 0, 0, 8'h00, 32'h0000_0000);
        push_op(KIND_LOAD_HELD, 0, 0, 8'h00, 0);
        push_op(KIND_QUERY, 0, 0, 0, 0);
        drain();

        // Directed part with six rows and three columns: indices out of range
        write_reg(CFG_NUM_PROCS, 4'd6);
        write_reg(CFG_NUM_RES, 4'd3);
        push_op(KIND_LOAD_MAX, 6, 0, 8'd1, 0);
        push_op(KIND_LOAD_HELD, 2, 3, 8'd1, 0);
        push_op(KIND_LOAD_FREE, 0, 3, 8'd1, 0);
        push_op(KIND_REQUEST, 7, 0, 0, 32'h0000_0000);
        push_op(KIND_REQUEST, 5, 0, 0, 32'h0101_0101);
        push_op(KIND_QUERY, 0, 0, 0, 0);
        drain();

        // Random part over several geometries, the clamped extremes among them
        run_phase(4'd8, 4'd4, 200, 1'b1, 1'b0);   // no idling on either side
        run_phase(4'd8, 4'd4, 200, 1'b0, 1'b1);   // long receiver hold-off
        run_phase(4'd1, 4'd1, 150, 1'b0, 1'b0);
        run_phase(4'd0, 4'd0, 100, 1'b0, 1'b0);
        run_phase(4'd15, 4'd7, 200, 1'b0, 1'b0);
        run_phase(4'd3, 4'd2, 200, 1'b0, 1'b0);
        run_phase(4'd5, 4'hB, 200, 1'b0, 1'b1);
        run_phase($urandom, $urandom, 300, 1'b0, 1'b0);
        run_phase($urandom, $urandom, 300, 1'b0, 1'b0);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
